/* hdl/gce_pkg.sv */
// ----------------------------------------------------------------------------
// Gini coefficient engine package
// Shared sizes, word types and sequencer states for the engine.
// ----------------------------------------------------------------------------
package gce_pkg;

   // Store capacity and the widths that follow from it.
   localparam int MAX_VALUES = 256;
   localparam int ADDR_W     = $clog2(MAX_VALUES);
   localparam int CNT_W      = $clog2(MAX_VALUES + 1);
   localparam int VALUE_W    = 32;
   localparam int TOTAL_W    = VALUE_W + CNT_W;
   localparam int WEIGHT_W   = CNT_W + 1;
   localparam int DEN_W      = TOTAL_W + CNT_W;
   localparam int PROD_W     = TOTAL_W + WEIGHT_W;
   localparam int GINI_W     = 16;
   localparam int STEP_W     = $clog2(GINI_W + 1);

   localparam logic [GINI_W-1:0] GINI_SAT  = {GINI_W{1'b1}};
   localparam logic [GINI_W-1:0] GINI_ZERO = {GINI_W{1'b0}};

   // Input word: one sample and its end-of-set mark.
   typedef struct packed {
      logic [VALUE_W-1:0] sample_value;
      logic               last_flag;
   } req_word_type;

   // Result word.
   typedef struct packed {
      logic [GINI_W-1:0] gini_value;
      logic              failed;
      logic              overflow;
   } rsp_word_type;

   // Sequencer states.
   typedef enum logic [2:0] {
      ST_LOAD,
      ST_RANK,
      ST_MUL,
      ST_ACC,
      ST_DEN_MUL,
      ST_DEN_CHK,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

/* hdl/gce_store.sv */
// ----------------------------------------------------------------------------
// Gini engine value store
// Sample memory with one write port and two registered read ports.
// ----------------------------------------------------------------------------
module gce_store
   import gce_pkg::*;
(
   input  logic               clock,
   input  logic               wr_en,
   input  logic [ADDR_W-1:0]  wr_addr,
   input  logic [VALUE_W-1:0] wr_data,
   input  logic [ADDR_W-1:0]  rd_addr_a,
   input  logic [ADDR_W-1:0]  rd_addr_b,
   output logic [VALUE_W-1:0] rd_data_a,
   output logic [VALUE_W-1:0] rd_data_b
);

   logic [VALUE_W-1:0] store_ff [MAX_VALUES];
   logic [VALUE_W-1:0] rd_a_ff;
   logic [VALUE_W-1:0] rd_b_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
   end

   // Two read ports with registered data.
   always_ff @(posedge clock) begin
      rd_a_ff <= store_ff[rd_addr_a];
      rd_b_ff <= store_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

/* hdl/gce_divider.sv */
// ----------------------------------------------------------------------------
// Gini engine fraction divider
// Restoring divider that forms floor(num * 2^16 / den), one bit per cycle.
// ----------------------------------------------------------------------------
module gce_divider
   import gce_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [DEN_W-1:0]  num,
   input  logic [DEN_W-1:0]  den,
   output logic              done,
   output logic [GINI_W-1:0] quotient
);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [DEN_W:0]    rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic [GINI_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]    shifted;
   logic [DEN_W:0]    diff;

   // One shift, compare and subtract step of the long division.
   always_comb begin
      shifted = {rem_ff[DEN_W-1:0], 1'b0};
      diff    = shifted - {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      step_in = step_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         rem_in  = {1'b0, num};
         den_in  = den;
         quo_in  = '0;
      end else if (busy_ff) begin
         if (shifted >= {1'b0, den_ff}) begin
            rem_in = diff;
            quo_in = {quo_ff[GINI_W-2:0], 1'b1};
         end else begin
            rem_in = shifted;
            quo_in = {quo_ff[GINI_W-2:0], 1'b0};
         end
         step_in = step_ff + STEP_W'(1);
         if (step_ff == STEP_W'(GINI_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      step_ff <= step_in;
      rem_ff  <= rem_in;
      den_ff  <= den_in;
      quo_ff  <= quo_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

/* hdl/gini_coefficient_engine_top.sv */
// ----------------------------------------------------------------------------
// Gini coefficient engine
// Loads a set of samples, ranks them and returns the Gini coefficient.
// ----------------------------------------------------------------------------
// Usage: samples arrive on the req_ channel, one word per cycle while the
// engine is loading. A word with last_flag set closes the set. Samples past
// the store capacity are dropped and flagged in the result's overflow bit.
// After the closing word the engine holds req_stall high while it works:
// every sample is ranked against all others with one shared comparator over
// the two read ports of the value store, its weighted term is formed on one
// shared multiplier, the fair area takes one more pass through that
// multiplier, and a restoring divider yields 16 fraction bits. No division
// is needed when the result fails or saturates.
// One result word leaves on the rsp_ channel per set; it sits in an output
// register, so a new set loads while it waits. If rsp_stall is still high
// when the next result is ready, the engine waits with req_stall high.
// Reset, synchronous and active high, empties the set and drops any pending
// result; the store itself needs no clearing.
// ----------------------------------------------------------------------------
module gini_coefficient_engine_top
   import gce_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_word_type req_word,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_word_type rsp_word
);

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              ovf_ff, ovf_in;
   logic [TOTAL_W-1:0] total_ff, total_in;
   logic [CNT_W-1:0]  j_ff, j_in;
   logic [CNT_W-1:0]  k_ff, k_in;
   logic [CNT_W-1:0]  kd_ff, kd_in;
   logic              cmp_vld_ff, cmp_vld_in;
   logic [CNT_W-1:0]  rank_ff, rank_in;
   logic [PROD_W-1:0] prod_ff, prod_in;
   logic [PROD_W-1:0] s_ff, s_in;
   logic [GINI_W-1:0] gini_ff, gini_in;
   logic              failed_ff, failed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   rsp_word_type      rsp_word_ff, rsp_word_in;

   logic               req_take;
   logic               store_wr;
   logic [VALUE_W-1:0] data_a, data_b;
   logic               less;
   logic               last_cmp;
   logic [CNT_W-1:0]   last_idx;
   logic [WEIGHT_W-1:0] weight;
   logic [TOTAL_W-1:0] mul_a;
   logic [WEIGHT_W-1:0] mul_b;
   logic [DEN_W-1:0]   den;
   logic [DEN_W-1:0]   num;
   logic               div_start;
   logic               div_done;
   logic [GINI_W-1:0]  div_quo;
   logic               out_free;

   // Sample memory.
   gce_store u_store (
      .clock     (clock),
      .wr_en     (store_wr),
      .wr_addr   (count_ff[ADDR_W-1:0]),
      .wr_data   (req_word.sample_value),
      .rd_addr_a (j_ff[ADDR_W-1:0]),
      .rd_addr_b (k_ff[ADDR_W-1:0]),
      .rd_data_a (data_a),
      .rd_data_b (data_b)
   );

   // Fraction divider.
   gce_divider u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .num      (num),
      .den      (den),
      .done     (div_done),
      .quotient (div_quo)
   );

   // Handshake and shared compare, weight and fraction terms.
   always_comb begin
      req_take = (state_ff == ST_LOAD) && req_valid;
      store_wr = req_take && (count_ff < CNT_W'(MAX_VALUES));
      last_idx = count_ff - CNT_W'(1);
      less     = (data_b < data_a) || ((data_b == data_a) && (kd_ff < j_ff));
      last_cmp = cmp_vld_ff && (kd_ff == last_idx);
      weight   = {count_ff - rank_ff, 1'b0} - WEIGHT_W'(1);
      den      = prod_ff[DEN_W-1:0];
      num      = (s_ff > PROD_W'(den)) ? '0 : (den - s_ff[DEN_W-1:0]);
      out_free = !rsp_valid_ff || !rsp_stall;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take && req_word.last_flag) begin
               state_in = ST_RANK;
            end
         end
         ST_RANK: begin
            if (last_cmp) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            state_in = ST_ACC;
         end
         ST_ACC: begin
            if (j_ff == last_idx) begin
               state_in = ST_DEN_MUL;
            end else begin
               state_in = ST_RANK;
            end
         end
         ST_DEN_MUL: begin
            state_in = ST_DEN_CHK;
         end
         ST_DEN_CHK: begin
            if ((den == '0) || (num >= den)) begin
               state_in = ST_DONE;
            end else begin
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               state_in = ST_LOAD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   // Datapath and output controls for each state.
   always_comb begin
      count_in     = count_ff;
      ovf_in       = ovf_ff;
      total_in     = total_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      kd_in        = k_ff;
      cmp_vld_in   = 1'b0;
      rank_in      = rank_ff;
      prod_in      = prod_ff;
      s_in         = s_ff;
      gini_in      = gini_ff;
      failed_in    = failed_ff;
      div_start    = 1'b0;
      mul_a        = total_ff;
      mul_b        = WEIGHT_W'(count_ff);
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         ST_LOAD: begin
            if (req_take) begin
               if (store_wr) begin
                  count_in = count_ff + CNT_W'(1);
                  total_in = total_ff + TOTAL_W'(req_word.sample_value);
               end else begin
                  ovf_in = 1'b1;
               end
               j_in    = '0;
               k_in    = '0;
               rank_in = '0;
               s_in    = '0;
            end
         end
         ST_RANK: begin
            // Issue one read per cycle; compare in the cycle after the read.
            if (k_ff < count_ff) begin
               k_in       = k_ff + CNT_W'(1);
               cmp_vld_in = 1'b1;
            end
            if (cmp_vld_ff && less) begin
               rank_in = rank_ff + CNT_W'(1);
            end
         end
         ST_MUL: begin
            // Sample times its weight 2*(n - rank) - 1.
            mul_a   = TOTAL_W'(data_a);
            mul_b   = weight;
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         ST_ACC: begin
            s_in    = s_ff + prod_ff;
            j_in    = j_ff + CNT_W'(1);
            k_in    = '0;
            rank_in = '0;
         end
         ST_DEN_MUL: begin
            // Doubled fair area: total times count.
            prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);
         end
         ST_DEN_CHK: begin
            if (den == '0) begin
               failed_in = 1'b1;
               gini_in   = GINI_ZERO;
            end else if (num >= den) begin
               failed_in = 1'b0;
               gini_in   = GINI_SAT;
            end else begin
               failed_in = 1'b0;
               div_start = 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               gini_in = div_quo;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.gini_value = gini_ff;
               rsp_word_in.failed     = failed_ff;
               rsp_word_in.overflow   = ovf_ff;
               count_in               = '0;
               ovf_in                 = 1'b0;
               total_in               = '0;
            end
         end
         default: begin
            count_in = '0;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         ovf_ff       <= 1'b0;
         total_ff     <= '0;
         cmp_vld_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         ovf_ff       <= ovf_in;
         total_ff     <= total_in;
         cmp_vld_ff   <= cmp_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      j_ff        <= j_in;
      k_ff        <= k_in;
      kd_ff       <= kd_in;
      rank_ff     <= rank_in;
      prod_ff     <= prod_in;
      s_ff        <= s_in;
      gini_ff     <= gini_in;
      failed_ff   <= failed_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign req_stall = (state_ff != ST_LOAD);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

/* dv/gini_coefficient_engine_top_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Gini coefficient engine testbench
// Streams sets of samples into the engine, predicts the Gini coefficient of
// each closed set from a sorted copy of the samples, and checks every result
// word against that prediction, with random idle bursts on both channels.
// ----------------------------------------------------------------------------
module gini_coefficient_engine_top_tb;
   import gce_pkg::*;

   // Value patterns used to fill random sets.
   typedef enum int unsigned {
      MIX_FULL,
      MIX_NARROW,
      MIX_ZERO,
      MIX_FLAT,
      MIX_SPARSE
   } value_mix_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_stall;
   req_word_type req_word;
   logic         rsp_valid;
   logic         rsp_stall;
   rsp_word_type rsp_word;

   // Mirror of the set being loaded and the results still owed.
   logic [VALUE_W-1:0] set_store [MAX_VALUES];
   int unsigned        set_size;
   bit                 set_dropped;
   rsp_word_type       pending_gini [$];

   logic [VALUE_W-1:0] batch [$];
   logic [VALUE_W-1:0] flat_value;
   bit                 sender_idles;
   bit                 receiver_idles;
   int unsigned        error_count;
   int unsigned        samples_sent;
   int unsigned        sets_closed;
   int unsigned        overflow_sets;
   int unsigned        failed_sets;

   gini_coefficient_engine_top uut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Expected result of the set now held: rank the samples, sum the doubled
   // trapezoid areas and divide the shortfall by the doubled fair area.
   function automatic rsp_word_type close_set();
      logic [VALUE_W-1:0] ranked [MAX_VALUES];
      logic [VALUE_W-1:0] key;
      logic [63:0]        prefix;
      logic [63:0]        area2;
      logic [63:0]        fair2;
      logic [63:0]        shortfall;
      logic [79:0]        scaled;
      rsp_word_type       result;
      int unsigned        i;
      int unsigned        j;
      for (i = 0; i < set_size; i++)
         ranked[i] = set_store[i];
      for (i = 1; i < set_size; i++) begin
         key = ranked[i];
         j   = i;
         while (j > 0 && ranked[j-1] > key) begin
            ranked[j] = ranked[j-1];
            j--;
         end
         ranked[j] = key;
      end
      prefix = '0;
      area2  = '0;
      for (i = 0; i < set_size; i++) begin
         prefix = prefix + ranked[i];
         area2  = area2 + (prefix << 1) - ranked[i];
      end
      fair2           = prefix * set_size;
      result.overflow = set_dropped;
      result.failed   = (fair2 == 0);
      if (result.failed) begin
         result.gini_value = GINI_ZERO;
      end else begin
         shortfall = (area2 > fair2) ? 64'd0 : fair2 - area2;
         if (shortfall >= fair2) begin
            result.gini_value = GINI_SAT;
         end else begin
            scaled            = {shortfall, 16'd0} / fair2;
            result.gini_value = scaled[GINI_W-1:0];
         end
      end
      return result;
   endfunction

   // Track one accepted word; a marked word closes the set.
   function automatic void take_sample(input req_word_type word);
      rsp_word_type closed;
      samples_sent++;
      if (set_size < MAX_VALUES) begin
         set_store[set_size] = word.sample_value;
         set_size++;
      end else begin
         set_dropped = 1'b1;
      end
      if (word.last_flag) begin
         closed = close_set();
         pending_gini.push_back(closed);
         sets_closed++;
         if (closed.overflow)
            overflow_sets++;
         if (closed.failed)
            failed_sets++;
         set_size    = 0;
         set_dropped = 1'b0;
      end
   endfunction

   function automatic logic [VALUE_W-1:0] pick_value(input value_mix_type mix);
      case (mix)
         MIX_FULL:   return $urandom;
         MIX_NARROW: return $urandom_range(0, 1000);
         MIX_ZERO:   return '0;
         MIX_FLAT:   return flat_value;
         default:    return ($urandom_range(0, 3) == 0) ? $urandom : 0;
      endcase
   endfunction

   // Offer one word, after an optional idle burst, and wait until it is taken.
   task automatic send_sample(input logic [VALUE_W-1:0] value, input logic closes);
      req_word_type word;
      word.sample_value = value;
      word.last_flag    = closes;
      if (sender_idles && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= word;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      take_sample(word);
   endtask

   // Send the queued batch as one set, marking its final word.
   task automatic send_batch();
      int unsigned i;
      for (i = 0; i < batch.size(); i++)
         send_sample(batch[i], i == batch.size() - 1);
   endtask

   // Hold the input quiet until every owed result has come back.
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_gini.size() != 0)
         @(posedge clock);
   endtask

   // Extreme values, single-sample sets, all-zero sets and even sets.
   task automatic test_directed_sets();
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      batch = '{32'hFFFF_FFFF};
      send_batch();
      batch = '{32'h0000_0000};
      send_batch();
      batch = '{32'h0, 32'h0, 32'h0};
      send_batch();
      batch = '{32'h0, 32'hFFFF_FFFF};
      send_batch();
      batch = '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA};
      send_batch();
      batch = '{32'd4, 32'd1, 32'd3, 32'd2};
      send_batch();
      batch = '{32'h0001_0000, 32'h0001_0000, 32'h0001_0000};
      send_batch();
      batch = '{32'h0, 32'h0, 32'h0, 32'h0, 32'h1};
      send_batch();
      batch = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
      send_batch();
   endtask

   // Fill the store exactly, then overfill it so the marked word is dropped.
   task automatic test_store_full();
      int unsigned i;
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      flat_value     = $urandom;
      batch.delete();
      for (i = 0; i < MAX_VALUES; i++)
         batch.push_back($urandom);
      send_batch();
      batch.delete();
      for (i = 0; i < MAX_VALUES + 2; i++)
         batch.push_back(pick_value(value_mix_type'($urandom_range(0, 4))));
      send_batch();
   endtask

   // A new set starts only after the engine has fully gone quiet.
   task automatic test_pause_between_sets();
      batch = '{32'h0000_0010, 32'h0000_0100, 32'h0000_1000};
      send_batch();
      drain_results();
      batch = '{32'h8000_0000, 32'h0000_0001};
      send_batch();
   endtask

   // Random sets, mostly short, with occasional longer ones and quiet spells.
   task automatic test_random_sets(input int unsigned sample_goal);
      value_mix_type mix;
      int unsigned   count;
      int unsigned   i;
      while (samples_sent < sample_goal) begin
         mix        = value_mix_type'($urandom_range(0, 4));
         flat_value = $urandom;
         if ($urandom_range(0, 9) == 0)
            count = $urandom_range(13, 48);
         else
            count = $urandom_range(1, 12);
         batch.delete();
         for (i = 0; i < count; i++)
            batch.push_back(pick_value(mix));
         send_batch();
         if ($urandom_range(0, 14) == 0)
            drain_results();
      end
   endtask

   // Result side: random stall bursts and the check of each taken word.
   initial begin : result_side
      int unsigned  hold;
      rsp_word_type want;
      hold = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (pending_gini.size() == 0) begin
               $display("%0t: result word %h arrived with none expected", $time, rsp_word);
               error_count++;
            end else begin
               want = pending_gini.pop_front();
               if (rsp_word.gini_value !== want.gini_value) begin
                  $display("%0t: gini_value expected %h actual %h",
                           $time, want.gini_value, rsp_word.gini_value);
                  error_count++;
               end
               if (rsp_word.failed !== want.failed) begin
                  $display("%0t: failed expected %b actual %b",
                           $time, want.failed, rsp_word.failed);
                  error_count++;
               end
               if (rsp_word.overflow !== want.overflow) begin
                  $display("%0t: overflow expected %b actual %b",
                           $time, want.overflow, rsp_word.overflow);
                  error_count++;
               end
            end
         end
         if (hold > 0) begin
            hold--;
            if (hold == 0)
               rsp_stall <= 1'b0;
         end else if (receiver_idles && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 13);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Main sequence.
   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_word  <= '0;
      set_size       = 0;
      set_dropped    = 1'b0;
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      error_count    = 0;
      samples_sent   = 0;
      sets_closed    = 0;
      overflow_sets  = 0;
      failed_sets    = 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_directed_sets();
      test_pause_between_sets();
      test_store_full();
      sender_idles   = 1'b1;
      receiver_idles = 1'b1;
      test_random_sets(1150);

      // Steady stream with no idling on either side.
      sender_idles   = 1'b0;
      receiver_idles = 1'b0;
      test_random_sets(1250);

      drain_results();
      repeat (40) @(posedge clock);
      $display("Checked %0d sets built from %0d samples.", sets_closed, samples_sent);
      $display("%0d sets overran the store and %0d had a zero total.",
               overflow_sets, failed_sets);
      if (error_count == 0)
         $display("gini_coefficient_engine_top test passed");
      else
         $display("gini_coefficient_engine_top test failed");
      $finish;
   end

   // Watchdog.
   initial begin
      #10_000_000;
      $display("gini_coefficient_engine_top test failed");
      $finish;
   end

endmodule

/* filelist.f */
hdl/gce_pkg.sv
hdl/gce_store.sv
hdl/gce_divider.sv
hdl/gini_coefficient_engine_top.sv
dv/gini_coefficient_engine_top_tb.sv
